[hw/rtl/memory_to_memory_machine_step_assert.svh]
// assertion macros shared by the machine step modules
// no dependencies; included by the modules that carry checks
`ifndef MEMORY_TO_MEMORY_MACHINE_STEP_ASSERT_SVH
`define MEMORY_TO_MEMORY_MACHINE_STEP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define M2M_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define M2M_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/m2m_pkg.sv]
// types, codes and helper functions of the memory-to-memory machine step
// no dependencies; used by every other file of the block but the ram and the assertion header
`default_nettype none

package m2m_pkg;

    // store geometry; depth must be a power of two
    localparam int MEM_DEPTH  = 1024;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // fixed field widths of the item and result words
    localparam int OPER_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int CODE_W   = 4;
    localparam int ARG_W    = 32;
    localparam int ARG3_W   = 10;
    localparam int VALUE_W  = 32;
    localparam int PC_W     = 10;
    localparam int STATUS_W = 2;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef enum logic [OPER_W-1:0] {
        OP_LD_INSTR = 2'd0,
        OP_LD_DATA  = 2'd1,
        OP_EXEC     = 2'd2
    } oper_t;

    typedef enum logic [CODE_W-1:0] {
        OPC_EMPTY = 4'd0,
        OPC_ADD   = 4'd1,
        OPC_MUL   = 4'd2,
        OPC_LE    = 4'd3,
        OPC_NEG   = 4'd4,
        OPC_JMP0  = 4'd5,
        OPC_ASS   = 4'd6,
        OPC_JMP   = 4'd7,
        OPC_READ  = 4'd8,
        OPC_WRITE = 4'd9,
        OPC_HALT  = 4'd10
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN     = 2'd0,
        ST_HALTED  = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_OPC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_OPER,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic [OPER_W-1:0]  operation;
        logic [SLOT_W-1:0]  slot_address;
        logic [CODE_W-1:0]  opcode;
        logic [ARG_W-1:0]   first_argument;
        logic [ARG_W-1:0]   second_argument;
        logic [ARG3_W-1:0]  third_argument;
        logic               first_is_address;
        logic               second_is_address;
        logic [VALUE_W-1:0] word_value;
    } item_t;

    typedef struct packed {
        logic [PC_W-1:0]     program_counter;
        logic                emit_valid;
        logic [VALUE_W-1:0]  emit_value;
        logic [STATUS_W-1:0] run_status;
    } result_t;

    // one instruction slot
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ARG_W-1:0]  a1;
        logic [ARG_W-1:0]  a2;
        logic [ARG3_W-1:0] a3;
        logic              f1;
        logic              f2;
    } instr_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic item_take;
        logic oper_step;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic exec_req;
        logic clear_last;
    } dp_status_t;

    // low address bits (depth is a power of two)
    function automatic addr_t addr_of(input logic [ARG_W-1:0] raw);
        return raw[ADDR_W-1:0];
    endfunction

    // sign-extend a field, then cut it to the machine word
    function automatic word_t imm_word(input logic [ARG_W-1:0] raw);
        logic [63:0] v;
        v = 64'($signed(raw));
        return v[WORD_WIDTH-1:0];
    endfunction

    // machine word back to the 32-bit output field
    function automatic logic [VALUE_W-1:0] sext_out(input word_t w);
        logic [63:0] v;
        v = 64'($signed(w));
        return v[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/m2m_in_if.sv]
// input channel of the machine step: valid/ready plus one item word
// depends on m2m_pkg for field widths
`default_nettype none

interface m2m_in_if;
    import m2m_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPER_W-1:0]    operation;
    logic [SLOT_W-1:0]    slot_address;
    logic [CODE_W-1:0]    opcode;
    logic [ARG_W-1:0]     first_argument;
    logic [ARG_W-1:0]     second_argument;
    logic [ARG3_W-1:0]    third_argument;
    logic                 first_is_address;
    logic                 second_is_address;
    logic [VALUE_W-1:0]   word_value;

    modport source (
        output valid, operation, slot_address, opcode, first_argument,
               second_argument, third_argument, first_is_address,
               second_is_address, word_value,
        input  ready
    );

    modport sink (
        input  valid, operation, slot_address, opcode, first_argument,
               second_argument, third_argument, first_is_address,
               second_is_address, word_value,
        output ready
    );

endinterface

`default_nettype wire

[hw/rtl/m2m_out_if.sv]
// output channel of the machine step: valid/ready plus one result word
// depends on m2m_pkg for field widths
`default_nettype none

interface m2m_out_if;
    import m2m_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PC_W-1:0]       program_counter;
    logic                  emit_valid;
    logic [VALUE_W-1:0]    emit_value;
    logic [STATUS_W-1:0]   run_status;

    modport source (
        output valid, program_counter, emit_valid, emit_value, run_status,
        input  ready
    );

    modport sink (
        input  valid, program_counter, emit_valid, emit_value, run_status,
        output ready
    );

endinterface

`default_nettype wire

[hw/rtl/m2m_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module m2m_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/m2m_ctrl.sv]
// sequencer of the machine step: clear pass, fetch, operand read, commit
// depends on m2m_pkg and the assertion macro header
`default_nettype none
`include "memory_to_memory_machine_step_assert.svh"

module m2m_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire m2m_pkg::dp_status_t status,
    output m2m_pkg::dp_cmd_t         cmd
);
    import m2m_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.item_take = 1'b1;
                    state_next    = status.exec_req ? S_OPER : S_COMMIT;
                end
            end
            S_OPER:
            begin
                cmd.oper_step = 1'b1;
                state_next    = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    `M2M_ASSERT_NEXT(a_commit_waits, clk, rst_n,
        state_reg == S_COMMIT && out_valid_reg && !out_ready,
        state_reg == S_COMMIT, "commit did not wait for the output slot")
    `M2M_ASSERT_NEXT(a_exec_reads_operands, clk, rst_n,
        in_valid && in_ready && status.exec_req,
        state_reg == S_OPER, "execute item skipped the operand read")
    `M2M_ASSERT_NEXT(a_clear_ends_idle, clk, rst_n,
        state_reg == S_CLEAR && status.clear_last,
        state_reg == S_IDLE && !out_valid_reg, "clear pass did not end cleanly")
    `M2M_ASSERT_NEXT(a_commit_shows_result, clk, rst_n,
        cmd.commit, out_valid_reg, "committed result not presented")

endmodule

`default_nettype wire

[hw/rtl/m2m_dp.sv]
// datapath of the machine step: stores, program counter, alu, result register
// depends on m2m_pkg, m2m_ram and the assertion macro header
`default_nettype none
`include "memory_to_memory_machine_step_assert.svh"

module m2m_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire m2m_pkg::item_t   in_item,
    input  wire m2m_pkg::dp_cmd_t cmd,
    output m2m_pkg::dp_status_t   status,
    output m2m_pkg::result_t      result
);
    import m2m_pkg::*;

    addr_t   clr_cnt_reg;
    addr_t   pc_reg;
    logic    stopped_reg;
    item_t   item_reg;
    instr_t  instr_reg;
    result_t res_reg;

    // instruction store port signals
    logic   iram_we;
    addr_t  iram_waddr;
    instr_t iram_wdata;
    logic   iram_re;
    addr_t  iram_raddr;
    instr_t iram_rdata;
    addr_t  jmp_target;

    // data store, two copies so both operands are read in the same cycle
    logic  dram_we;
    addr_t dram_waddr;
    word_t dram_wdata;
    word_t d1_rdata;
    word_t d2_rdata;

    // execute results
    word_t   op_x;
    word_t   op_y;
    word_t   prod;
    logic    ex_wr;
    addr_t   ex_dest;
    word_t   ex_val;
    addr_t   ex_pc;
    status_t ex_status;
    logic    ex_emit;
    logic    ex_halt;
    logic    is_exec;
    result_t res_next;

    assign status.exec_req   = (in_item.operation == OP_EXEC) && !stopped_reg;
    assign status.clear_last = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
    assign result            = res_reg;

    assign is_exec = (item_reg.operation == OP_EXEC) && !stopped_reg;

    // instruction store: cleared, loaded, read at pc then at the jump target
    assign jmp_target = (iram_rdata.code == OPC_JMP) ? addr_of(iram_rdata.a1)
                                                     : addr_of(iram_rdata.a2);
    assign iram_we    = cmd.clear_step
                     || (cmd.commit && item_reg.operation == OP_LD_INSTR);
    assign iram_waddr = cmd.clear_step ? clr_cnt_reg
                                       : addr_of(ARG_W'(item_reg.slot_address));
    assign iram_wdata = cmd.clear_step ? '0 :
                        '{code: item_reg.opcode,
                          a1:   item_reg.first_argument,
                          a2:   item_reg.second_argument,
                          a3:   item_reg.third_argument,
                          f1:   item_reg.first_is_address,
                          f2:   item_reg.second_is_address};
    assign iram_re    = cmd.item_take || cmd.oper_step;
    assign iram_raddr = cmd.item_take ? pc_reg : jmp_target;

    m2m_ram #(
        .WIDTH ($bits(instr_t)),
        .DEPTH (MEM_DEPTH)
    ) u_instr_ram (
        .clk   (clk),
        .we    (iram_we),
        .waddr (iram_waddr),
        .wdata (iram_wdata),
        .re    (iram_re),
        .raddr (iram_raddr),
        .rdata (iram_rdata)
    );

    assign dram_we = cmd.clear_step
                  || (cmd.commit && item_reg.operation == OP_LD_DATA)
                  || (cmd.commit && is_exec && ex_wr);

    always_comb
    begin
        if (cmd.clear_step)
        begin
            dram_waddr = clr_cnt_reg;
            dram_wdata = '1;
        end
        else if (item_reg.operation == OP_LD_DATA)
        begin
            dram_waddr = addr_of(ARG_W'(item_reg.slot_address));
            dram_wdata = imm_word(item_reg.word_value);
        end
        else
        begin
            dram_waddr = ex_dest;
            dram_wdata = ex_val;
        end
    end

    m2m_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_data_ram_a (
        .clk   (clk),
        .we    (dram_we),
        .waddr (dram_waddr),
        .wdata (dram_wdata),
        .re    (cmd.oper_step),
        .raddr (addr_of(iram_rdata.a1)),
        .rdata (d1_rdata)
    );

    m2m_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_data_ram_b (
        .clk   (clk),
        .we    (dram_we),
        .waddr (dram_waddr),
        .wdata (dram_wdata),
        .re    (cmd.oper_step),
        .raddr (addr_of(iram_rdata.a2)),
        .rdata (d2_rdata)
    );

    // operands and alu
    assign op_x = instr_reg.f1 ? d1_rdata : imm_word(instr_reg.a1);
    assign op_y = instr_reg.f2 ? d2_rdata : imm_word(instr_reg.a2);
    assign prod = op_x * op_y;

    always_comb
    begin
        ex_wr     = 1'b0;
        ex_dest   = addr_of(ARG_W'(instr_reg.a3));
        ex_val    = op_x + op_y;
        ex_pc     = pc_reg + ADDR_W'(1);
        ex_status = ST_RUN;
        ex_emit   = 1'b0;
        ex_halt   = 1'b0;
        case (instr_reg.code)
            OPC_EMPTY:
            begin
                ex_pc     = pc_reg;
                ex_status = ST_EMPTY;
            end
            OPC_ADD:
            begin
                ex_wr = 1'b1;
            end
            OPC_MUL:
            begin
                ex_wr  = 1'b1;
                ex_val = prod;
            end
            OPC_LE:
            begin
                ex_wr  = 1'b1;
                ex_val = {{(WORD_WIDTH-1){1'b0}}, ($signed(op_x) <= $signed(op_y))};
            end
            OPC_NEG:
            begin
                ex_wr   = 1'b1;
                ex_dest = addr_of(instr_reg.a2);
                ex_val  = '0 - op_x;
            end
            OPC_JMP0:
            begin
                // iram read data now holds the target slot
                if (op_x == '0 && iram_rdata.code != OPC_EMPTY)
                begin
                    ex_pc = addr_of(instr_reg.a2);
                end
            end
            OPC_ASS:
            begin
                ex_wr   = 1'b1;
                ex_dest = addr_of(instr_reg.a2);
                ex_val  = op_x;
            end
            OPC_JMP:
            begin
                if (iram_rdata.code != OPC_EMPTY)
                begin
                    ex_pc = addr_of(instr_reg.a1);
                end
            end
            OPC_READ:
            begin
                ex_wr   = 1'b1;
                ex_dest = addr_of(instr_reg.a1);
                ex_val  = imm_word(item_reg.word_value);
            end
            OPC_WRITE:
            begin
                ex_emit = 1'b1;
            end
            OPC_HALT:
            begin
                ex_halt   = 1'b1;
                ex_pc     = pc_reg;
                ex_status = ST_HALTED;
            end
            default:
            begin
                ex_pc     = pc_reg;
                ex_status = ST_BAD_OPC;
            end
        endcase
    end

    always_comb
    begin
        res_next.program_counter = PC_W'(is_exec ? ex_pc : pc_reg);
        res_next.emit_valid      = is_exec && ex_emit;
        res_next.emit_value      = (is_exec && ex_emit) ? sext_out(op_x) : '0;
        res_next.run_status      = is_exec ? ex_status
                                           : (stopped_reg ? ST_HALTED : ST_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.commit && is_exec)
            begin
                pc_reg <= ex_pc;
                if (ex_halt)
                begin
                    stopped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_take)
        begin
            item_reg <= in_item;
        end
        if (cmd.oper_step)
        begin
            instr_reg <= iram_rdata;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    `M2M_ASSERT_NEXT(a_halt_sticky, clk, rst_n,
        stopped_reg, stopped_reg, "halt flag dropped without reset")
    `M2M_ASSERT_NOW(a_no_exec_when_stopped, clk, rst_n,
        cmd.commit && stopped_reg, $stable(pc_reg), "pc moved while halted")

endmodule

`default_nettype wire

[hw/rtl/memory_to_memory_machine_step.sv]
// top level of the memory-to-memory machine step
// depends on m2m_pkg, m2m_in_if, m2m_out_if, m2m_ctrl and m2m_dp
`default_nettype none

// Memory-to-memory machine that advances by one item at a time. Each input
// word either loads an instruction slot, loads a data word, or executes the
// instruction at the program counter; every input word returns exactly one
// result word with the new program counter, a WRITE value if one was emitted
// and the run status. After reset the block runs a clearing pass over all
// MEM_DEPTH (1024) slots that marks every instruction slot empty and sets
// every data word to minus one; ready stays low during that pass. Items are
// handled one at a time: a load goes from accept straight to commit, while
// an execute passes through the registered reads of the instruction and data
// memories (fetch at pc, then operands and jump target, then write back). A
// result waits in the output register until taken; the block holds the next
// item's commit until that register frees, so a stalled sink holds up items.
module memory_to_memory_machine_step (
    input wire logic  clk,
    input wire logic  rst_n,
    m2m_in_if.sink    item,
    m2m_out_if.source result
);
    import m2m_pkg::*;

    item_t      item_s;
    result_t    result_s;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // gather the input word fields into one struct
    assign item_s.operation         = item.operation;
    assign item_s.slot_address      = item.slot_address;
    assign item_s.opcode            = item.opcode;
    assign item_s.first_argument    = item.first_argument;
    assign item_s.second_argument   = item.second_argument;
    assign item_s.third_argument    = item.third_argument;
    assign item_s.first_is_address  = item.first_is_address;
    assign item_s.second_is_address = item.second_is_address;
    assign item_s.word_value        = item.word_value;

    // sequencer: clear pass, accept, operand read, commit
    m2m_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // stores, pc, alu and the output register
    m2m_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (item_s),
        .cmd     (dp_cmd),
        .status  (dp_status),
        .result  (result_s)
    );

    // spread the result word onto the output channel
    assign result.program_counter = result_s.program_counter;
    assign result.emit_valid      = result_s.emit_valid;
    assign result.emit_value      = result_s.emit_value;
    assign result.run_status      = result_s.run_status;

endmodule

`default_nettype wire

[dv/tb_memory_to_memory_machine_step.sv]
`timescale 1ns / 1ps
// testbench for the memory-to-memory machine step: directed programs, random programs, halt
// depends on m2m_pkg, m2m_in_if, m2m_out_if and memory_to_memory_machine_step
module tb_memory_to_memory_machine_step;
    import m2m_pkg::*;

    localparam logic [OPER_W-1:0] OPER_UNUSED = 2'd3;   // operation code the block ignores
    localparam int OPC_MAX      = (1 << CODE_W) - 1;
    localparam int TIMEOUT_NS   = 800_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_WORDS = 1320;
    localparam int CALM_WORDS   = 300;                  // closing stretch with no idling

    logic clk;
    logic rst_n;

    m2m_in_if  in_ch ();
    m2m_out_if out_ch ();

    memory_to_memory_machine_step dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    // machine state as the checker sees it
    instr_t  exp_slots [MEM_DEPTH];
    word_t   exp_words [MEM_DEPTH];
    addr_t   exp_pc;
    logic    exp_halted;

    result_t pending_results [$];
    result_t seen_result;
    int      error_count;
    int      words_sent;
    bit      sender_idles;
    bit      sink_idles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // 32-bit field pattern to machine word
    function automatic word_t as_word(input logic [ARG_W-1:0] raw);
        return WORD_WIDTH'($signed(raw));
    endfunction

    // immediate, or the data word that the low address bits name
    function automatic word_t fetch_operand(input logic [ARG_W-1:0] raw, input logic is_addr);
        return is_addr ? exp_words[addr_t'(raw)] : as_word(raw);
    endfunction

    // apply one accepted input word to the machine state and form its result word
    function automatic result_t step_machine(input item_t w);
        result_t r;
        instr_t  s;
        word_t   x;
        word_t   y;
        addr_t   nxt;
        addr_t   tgt;
        r = '0;
        r.run_status = exp_halted ? ST_HALTED : ST_RUN;
        if (w.operation == OP_LD_INSTR) begin
            s.code = w.opcode;
            s.a1   = w.first_argument;
            s.a2   = w.second_argument;
            s.a3   = w.third_argument;
            s.f1   = w.first_is_address;
            s.f2   = w.second_is_address;
            exp_slots[addr_t'(w.slot_address)] = s;
        end else if (w.operation == OP_LD_DATA) begin
            exp_words[addr_t'(w.slot_address)] = as_word(w.word_value);
        end else if (w.operation == OP_EXEC && !exp_halted) begin
            s   = exp_slots[exp_pc];
            nxt = exp_pc + 1'b1;
            case (s.code)
                OPC_EMPTY: begin
                    // stuck until the slot gets loaded
                    nxt = exp_pc;
                    r.run_status = ST_EMPTY;
                end
                OPC_ADD, OPC_MUL, OPC_LE: begin
                    x = fetch_operand(s.a1, s.f1);
                    y = fetch_operand(s.a2, s.f2);
                    if (s.code == OPC_ADD)
                        x = x + y;
                    else if (s.code == OPC_MUL)
                        x = x * y;
                    else
                        x = ($signed(x) <= $signed(y)) ? word_t'(1) : word_t'(0);
                    exp_words[addr_t'(s.a3)] = x;
                end
                OPC_NEG: begin
                    exp_words[addr_t'(s.a2)] = word_t'(0) - fetch_operand(s.a1, s.f1);
                end
                OPC_JMP0: begin
                    tgt = addr_t'(s.a2);
                    if (fetch_operand(s.a1, s.f1) == word_t'(0) && exp_slots[tgt].code != OPC_EMPTY)
                        nxt = tgt;
                end
                OPC_ASS: begin
                    exp_words[addr_t'(s.a2)] = fetch_operand(s.a1, s.f1);
                end
                OPC_JMP: begin
                    tgt = addr_t'(s.a1);
                    if (exp_slots[tgt].code != OPC_EMPTY)
                        nxt = tgt;
                end
                OPC_READ: begin
                    // the address flag plays no part here
                    exp_words[addr_t'(s.a1)] = as_word(w.word_value);
                end
                OPC_WRITE: begin
                    r.emit_valid = 1'b1;
                    r.emit_value = VALUE_W'($signed(fetch_operand(s.a1, s.f1)));
                end
                OPC_HALT: begin
                    exp_halted   = 1'b1;
                    nxt          = exp_pc;
                    r.run_status = ST_HALTED;
                end
                default: begin
                    nxt = exp_pc;
                    r.run_status = ST_BAD_OPC;
                end
            endcase
            exp_pc = nxt;
        end
        r.program_counter = exp_pc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // zero, one, the extremes and random values, weighted toward the special ones
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFF;
            5: return 32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    // address operand: mostly a small data window, upper bits often junk
    function automatic logic [31:0] data_addr_arg();
        logic [31:0] raw;
        raw = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        raw[ADDR_W-1:0] = ($urandom_range(0, 4) != 0) ? addr_t'($urandom_range(0, 31))
                                                       : addr_t'($urandom);
        return raw;
    endfunction

    // jump target: mostly close to the current pc so that jumps get taken
    function automatic logic [31:0] jump_target();
        logic [31:0] raw;
        raw = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        raw[ADDR_W-1:0] = ($urandom_range(0, 9) < 7)
                          ? addr_t'(int'(exp_pc) + $urandom_range(0, 23) - 8)
                          : addr_t'($urandom);
        return raw;
    endfunction

    function automatic item_t random_item(input logic [OPER_W-1:0] oper);
        item_t w;
        w.operation         = oper;
        w.slot_address      = SLOT_W'($urandom);
        w.opcode            = CODE_W'($urandom);
        w.first_argument    = $urandom;
        w.second_argument   = $urandom;
        w.third_argument    = ARG3_W'($urandom);
        w.first_is_address  = 1'($urandom);
        w.second_is_address = 1'($urandom);
        w.word_value        = rand_value();
        return w;
    endfunction

    // a mostly runnable instruction for one slot, at times empty or an unknown code; halt is kept for the closing test
    function automatic item_t instr_item(input addr_t slot);
        item_t w;
        int    pick;
        w = random_item(OP_LD_INSTR);
        w.slot_address = slot;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            w.opcode = OPC_EMPTY;
        else if (pick == 1)
            w.opcode = CODE_W'($urandom_range(int'(OPC_HALT) + 1, OPC_MAX));
        else
            w.opcode = CODE_W'($urandom_range(int'(OPC_ADD), int'(OPC_WRITE)));
        w.first_argument  = w.first_is_address ? data_addr_arg() : rand_value();
        w.second_argument = w.second_is_address ? data_addr_arg() : rand_value();
        w.third_argument  = ARG3_W'(data_addr_arg());
        case (w.opcode)
            OPC_NEG, OPC_ASS: w.second_argument = data_addr_arg();
            OPC_READ:         w.first_argument  = data_addr_arg();
            OPC_JMP:          w.first_argument  = jump_target();
            OPC_JMP0: begin
                w.second_argument = jump_target();
                if (!w.first_is_address && $urandom_range(0, 9) < 4)
                    w.first_argument = 32'd0;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic item_t code_item(input addr_t slot, input opcode_t code,
                                        input logic [31:0] a1, input logic [31:0] a2,
                                        input logic [ARG3_W-1:0] a3, input logic f1,
                                        input logic f2);
        item_t w;
        w = '0;
        w.operation         = OP_LD_INSTR;
        w.slot_address      = slot;
        w.opcode            = code;
        w.first_argument    = a1;
        w.second_argument   = a2;
        w.third_argument    = a3;
        w.first_is_address  = f1;
        w.second_is_address = f2;
        return w;
    endfunction

    function automatic item_t plain_item(input logic [OPER_W-1:0] oper, input addr_t slot,
                                         input logic [31:0] value);
        item_t w;
        w = '0;
        w.operation    = oper;
        w.slot_address = slot;
        w.word_value   = value;
        return w;
    endfunction

    // one input word: optional gap, then hold valid until accepted.
    // valid stays high on return so back-to-back words need no second drive
    task automatic send_word(input item_t w);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.operation         <= w.operation;
        in_ch.slot_address      <= w.slot_address;
        in_ch.opcode            <= w.opcode;
        in_ch.first_argument    <= w.first_argument;
        in_ch.second_argument   <= w.second_argument;
        in_ch.third_argument    <= w.third_argument;
        in_ch.first_is_address  <= w.first_is_address;
        in_ch.second_is_address <= w.second_is_address;
        in_ch.word_value        <= w.word_value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(step_machine(w));
        if (w.operation != OPER_UNUSED)
            words_sent++;
    endtask

    // hold the sender off until every result word is back
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // execute on the empty store, the ignored operation code, data word extremes
    task automatic test_empty_and_loads();
        item_t w;
        send_word(plain_item(OP_EXEC, 0, 32'h1234_5678));
        w = random_item(OPER_UNUSED);
        send_word(w);
        send_word(plain_item(OP_LD_DATA, addr_t'(MEM_DEPTH - 1), 32'h8000_0000));
        send_word(plain_item(OP_LD_DATA, addr_t'(MEM_DEPTH - 2), 32'h7FFF_FFFF));
    endtask

    // a short program that runs each opcode but halt and empty once, then an unknown code
    task automatic test_each_opcode();
        // max + 1 wraps to min, min * -1 stays min, min <= min is true
        send_word(code_item(0, OPC_ADD, MEM_DEPTH - 2, 32'd1, 10'd3, 1'b1, 1'b0));
        send_word(code_item(1, OPC_MUL, 32'd3, 32'hFFFF_FFFF, 10'd4, 1'b1, 1'b0));
        send_word(code_item(2, OPC_LE, 32'd4, MEM_DEPTH - 1, 10'd5, 1'b1, 1'b1));
        // destination addresses with junk in the upper bits
        send_word(code_item(3, OPC_NEG, 32'h8000_0000, 32'hFFFF_FC06, 10'd0, 1'b0, 1'b1));
        send_word(code_item(4, OPC_READ, 32'hFFFF_FC07, 32'd0, 10'd0, 1'b1, 1'b1));
        // zero operand, target loaded: jump taken
        send_word(code_item(5, OPC_JMP0, 32'd0, 32'd8, 10'd0, 1'b0, 1'b0));
        send_word(code_item(8, OPC_ASS, 32'd7, 32'd9, 10'd0, 1'b1, 1'b0));
        send_word(code_item(9, OPC_WRITE, 32'd9, 32'd0, 10'd0, 1'b1, 1'b0));
        // target slot empty: jump not taken
        send_word(code_item(10, OPC_JMP, 32'd30, 32'd0, 10'd0, 1'b0, 1'b0));
        send_word(code_item(11, opcode_t'(OPC_MAX), 32'd0, 32'd0, 10'd0, 1'b0, 1'b0));
        repeat (6)
            send_word(plain_item(OP_EXEC, 0, 32'h8000_0000));
        repeat (4)
            send_word(plain_item(OP_EXEC, 0, 32'hFFFF_FFFF));
    endtask

    // mostly runnable programs with random content, some noise mixed in
    task automatic test_random_programs(input int count);
        int    start;
        int    roll;
        bit    drained;
        item_t w;
        start   = words_sent;
        drained = 1'b0;
        while (words_sent - start < count) begin
            if (words_sent - start >= count - CALM_WORDS) begin
                if (!drained) begin
                    pause_until_drained();
                    drained = 1'b1;
                end
                sender_idles = 1'b0;
                sink_idles   = 1'b0;
            end else if ($urandom_range(0, 59) == 0) begin
                sender_idles = 1'($urandom);
                sink_idles   = 1'($urandom);
            end
            if ($urandom_range(0, 199) == 0)
                pause_until_drained();
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                // make the slot at pc runnable most of the time, then step
                if ((exp_slots[exp_pc].code == OPC_EMPTY || exp_slots[exp_pc].code > OPC_HALT)
                    && $urandom_range(0, 9) < 8)
                    send_word(instr_item(exp_pc));
                send_word(random_item(OP_EXEC));
            end else if (roll < 75) begin
                send_word(instr_item(addr_t'(int'(exp_pc) + $urandom_range(0, 15))));
            end else if (roll < 90) begin
                w = random_item(OP_LD_DATA);
                w.slot_address = SLOT_W'(data_addr_arg());
                send_word(w);
            end else begin
                // noise: ignored operation, or a raw instruction anywhere
                w = random_item(($urandom_range(0, 1) == 0) ? OPER_UNUSED : OP_LD_INSTR);
                if (w.operation == OP_LD_INSTR && w.opcode == OPC_HALT)
                    w.opcode = OPC_EMPTY;
                send_word(w);
            end
        end
    endtask

    // halt at pc, then everything that follows reports halted
    task automatic test_halt_and_after();
        item_t w;
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        w = random_item(OP_LD_INSTR);
        w.slot_address = exp_pc;
        w.opcode       = OPC_HALT;
        send_word(w);
        send_word(random_item(OP_EXEC));
        send_word(random_item(OP_EXEC));
        repeat (40)
            send_word(random_item(OPER_W'($urandom_range(0, 3))));
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // sink stalls in bursts while enabled
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            if (sink_idles && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // every result word against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual pc %0h emit %0b %0h status %0h",
                         $time, out_ch.program_counter, out_ch.emit_valid, out_ch.emit_value,
                         out_ch.run_status);
                error_count++;
            end else begin
                seen_result = pending_results.pop_front();
                report_field("program_counter", 32'(seen_result.program_counter),
                             32'(out_ch.program_counter));
                report_field("emit_valid", 32'(seen_result.emit_valid), 32'(out_ch.emit_valid));
                report_field("emit_value", seen_result.emit_value, out_ch.emit_value);
                report_field("run_status", 32'(seen_result.run_status), 32'(out_ch.run_status));
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n        = 1'b0;
        error_count  = 0;
        words_sent   = 0;
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        in_ch.valid             = 1'b0;
        in_ch.operation         = '0;
        in_ch.slot_address      = '0;
        in_ch.opcode            = '0;
        in_ch.first_argument    = '0;
        in_ch.second_argument   = '0;
        in_ch.third_argument    = '0;
        in_ch.first_is_address  = 1'b0;
        in_ch.second_is_address = 1'b0;
        in_ch.word_value        = '0;
        // state after reset: slots empty, words minus one
        for (int i = 0; i < MEM_DEPTH; i++) begin
            exp_slots[i] = '0;
            exp_words[i] = '1;
        end
        exp_pc     = '0;
        exp_halted = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ready stays low through the clearing pass; send_word waits on it
        test_empty_and_loads();
        test_each_opcode();
        test_random_programs(RANDOM_WORDS);
        test_halt_and_after();

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
